// ===== design/bdbp_pkg.sv =====
// Package for the byte distribution bit predictor.
// Holds sizes, action codes and the sequencer state type; no dependencies.
package bdbp_pkg;
	localparam int SYMBOL_COUNT = 256;
	localparam int COUNT_BITS = 24;
	localparam int SYM_BITS = $clog2(SYMBOL_COUNT);
	localparam int SUM_BITS = COUNT_BITS + SYM_BITS;
	localparam int PROB_BITS = 16;
	localparam int DIV_BITS = SUM_BITS + PROB_BITS;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_OBSERVE = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SWEEP_WAIT,
		ST_RD_LO,
		ST_RD_MID,
		ST_RD_HI,
		ST_RD_DONE,
		ST_DIVIDE,
		ST_ARGMAX,
		ST_ARGMAX_LAST,
		ST_DONE
	} state_t;
endpackage

// ===== design/byte_distribution_bit_predictor_core.sv =====
// Top level of the byte distribution bit predictor.
// Depends on bdbp_pkg and bdbp_divider.
//
// One request at a time: busy is high from the accepting edge until the
// cycle of the result strobe. An observe or unused request goes through
// three prefix-sum reads, a 48-step serial divide, then an argmax walk over
// the n symbols in the range after the update (1 to 256) that reads one
// weight per cycle from the weight memory. A load without last_entry writes
// its weight at the accepting edge and then takes the same path. A load with
// last_entry or a restart first sweeps all 256 weights to rebuild the prefix
// sums. The receiver cannot stall: each result is shown for one cycle on
// done. After reset busy stays high for a pass that sets the memories to
// their reset contents.
module byte_distribution_bit_predictor_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [7:0] symbol_index,
	input logic [23:0] symbol_count,
	input logic last_entry,
	input logic bit_value,
	output logic done,
	output logic [15:0] prob_one,
	output logic [7:0] likely_symbol,
	output logic [7:0] range_low,
	output logic [7:0] range_high,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	localparam int SB = bdbp_pkg::SYM_BITS;
	localparam int CB = bdbp_pkg::COUNT_BITS;
	localparam int PB = bdbp_pkg::SUM_BITS;

	logic [63:0] mask_q [4];
	logic [CB-1:0] wmem [bdbp_pkg::SYMBOL_COUNT];
	logic [PB-1:0] pmem [bdbp_pkg::SYMBOL_COUNT+1];

	bdbp_pkg::state_t state_q, state_d;
	logic init_q;
	logic restart_q;
	logic [SB:0] idx_q;
	logic [SB-1:0] lo_q, hi_q, best_q, mid;
	logic [PB-1:0] acc_q, p_lo_q, p_mid_q;
	logic [CB-1:0] best_w_q;
	logic [CB-1:0] w_rd;
	logic [PB-1:0] p_rd;
	logic w_we, p_we;
	logic [SB-1:0] w_waddr, w_raddr;
	logic [SB:0] p_waddr, p_raddr;
	logic [CB-1:0] w_wdata;
	logic [PB-1:0] p_wdata;
	logic [SB-1:0] sweep_sym, prev_sym;
	logic sweep_allowed, load_allowed;
	logic [CB-1:0] sweep_w;
	logic [PB-1:0] sweep_sum;
	logic div_start, div_done;
	logic [15:0] quot;
	logic [PB-1:0] upper_mass, total_mass;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != bdbp_pkg::ST_IDLE);
	assign mid = lo_q + SB'((hi_q - lo_q) >> 1);
	assign sweep_sym = idx_q[SB-1:0];
	assign prev_sym = SB'(idx_q - 1'b1);
	assign sweep_allowed = !restart_q || mask_q[prev_sym[SB-1:6]][prev_sym[5:0]];
	assign sweep_w = (idx_q == '0 || !sweep_allowed) ? '0 : w_rd;
	assign sweep_sum = acc_q + PB'(sweep_w);
	assign load_allowed = mask_q[symbol_index[7:6]][symbol_index[5:0]];
	assign upper_mass = p_rd - p_mid_q;
	assign total_mass = p_rd - p_lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) mask_q[i] <= '1;
		end else if (cfg_valid && cfg_ready) begin
			mask_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_waddr] <= w_wdata;
		w_rd <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) pmem[p_waddr] <= p_wdata;
		p_rd <= pmem[p_raddr];
	end

	bdbp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.upper(upper_mass), .total(total_mass),
		.done(div_done), .quotient(quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdbp_pkg::ST_IDLE: begin
				if (start) begin
					if (action == bdbp_pkg::ACT_RESTART
						|| (action == bdbp_pkg::ACT_LOAD && last_entry)) begin
						state_d = bdbp_pkg::ST_SWEEP;
					end else begin
						state_d = bdbp_pkg::ST_RD_LO;
					end
				end
			end
			bdbp_pkg::ST_SWEEP: begin
				if (idx_q == (SB+1)'(bdbp_pkg::SYMBOL_COUNT)) state_d = bdbp_pkg::ST_SWEEP_WAIT;
			end
			bdbp_pkg::ST_SWEEP_WAIT: state_d = init_q ? bdbp_pkg::ST_IDLE : bdbp_pkg::ST_RD_LO;
			bdbp_pkg::ST_RD_LO: state_d = bdbp_pkg::ST_RD_MID;
			bdbp_pkg::ST_RD_MID: state_d = bdbp_pkg::ST_RD_HI;
			bdbp_pkg::ST_RD_HI: state_d = bdbp_pkg::ST_RD_DONE;
			bdbp_pkg::ST_RD_DONE: state_d = bdbp_pkg::ST_DIVIDE;
			bdbp_pkg::ST_DIVIDE: if (div_done) state_d = bdbp_pkg::ST_ARGMAX;
			bdbp_pkg::ST_ARGMAX: begin
				if (idx_q[SB-1:0] == hi_q) state_d = bdbp_pkg::ST_ARGMAX_LAST;
			end
			bdbp_pkg::ST_ARGMAX_LAST: state_d = bdbp_pkg::ST_DONE;
			bdbp_pkg::ST_DONE: state_d = bdbp_pkg::ST_IDLE;
			default: state_d = bdbp_pkg::ST_IDLE;
		endcase
	end

	// Memory ports. During the sweep, the weight read runs one entry ahead
	// of the weight write-back and shares its index with the prefix-sum write.
	always_comb begin
		w_we = 1'b0;
		w_waddr = sweep_sym;
		w_wdata = w_rd;
		w_raddr = sweep_sym;
		p_we = 1'b0;
		p_waddr = idx_q;
		p_wdata = acc_q;
		p_raddr = {1'b0, lo_q};
		div_start = 1'b0;
		unique case (state_q)
			bdbp_pkg::ST_IDLE: begin
				if (start && action == bdbp_pkg::ACT_LOAD && symbol_index < 9'(bdbp_pkg::SYMBOL_COUNT)) begin
					w_we = 1'b1;
					w_waddr = symbol_index;
					if (!load_allowed) w_wdata = '0;
					else if (symbol_count == '0) w_wdata = CB'(1);
					else w_wdata = symbol_count;
				end
				w_raddr = '0;
			end
			bdbp_pkg::ST_SWEEP: begin
				w_raddr = SB'(idx_q);
				if (init_q) begin
					p_we = 1'b1;
					p_wdata = PB'(idx_q);
					w_we = (idx_q != (SB+1)'(bdbp_pkg::SYMBOL_COUNT));
					w_wdata = CB'(1);
				end else begin
					p_we = 1'b1;
					p_wdata = sweep_sum;
					if (idx_q != '0) begin
						w_we = 1'b1;
						w_waddr = prev_sym;
						w_wdata = sweep_w;
					end
				end
			end
			bdbp_pkg::ST_RD_LO: p_raddr = {1'b0, lo_q};
			bdbp_pkg::ST_RD_MID: p_raddr = (SB+1)'(mid) + 1'b1;
			bdbp_pkg::ST_RD_HI: p_raddr = (SB+1)'(hi_q) + 1'b1;
			bdbp_pkg::ST_RD_DONE: div_start = 1'b0;
			bdbp_pkg::ST_DIVIDE: w_raddr = lo_q;
			bdbp_pkg::ST_ARGMAX: w_raddr = idx_q[SB-1:0] + 1'b1;
			default: w_raddr = sweep_sym;
		endcase
		if (state_q == bdbp_pkg::ST_RD_DONE) div_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdbp_pkg::ST_SWEEP;
			init_q <= 1'b1;
			restart_q <= 1'b0;
			idx_q <= '0;
			lo_q <= '0;
			hi_q <= '1;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == bdbp_pkg::ST_DONE);
			if (state_q == bdbp_pkg::ST_SWEEP_WAIT) init_q <= 1'b0;
			unique case (state_q)
				bdbp_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						restart_q <= (action == bdbp_pkg::ACT_RESTART);
						if (action == bdbp_pkg::ACT_OBSERVE && lo_q < hi_q) begin
							if (bit_value) lo_q <= mid + 1'b1;
							else hi_q <= mid;
						end
						if (action == bdbp_pkg::ACT_RESTART
							|| (action == bdbp_pkg::ACT_LOAD && last_entry)) begin
							lo_q <= '0;
							hi_q <= '1;
						end
					end
				end
				bdbp_pkg::ST_SWEEP: idx_q <= idx_q + 1'b1;
				bdbp_pkg::ST_ARGMAX: idx_q <= idx_q + 1'b1;
				bdbp_pkg::ST_DIVIDE: idx_q <= (SB+1)'(lo_q);
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Datapath registers: running sum, prefix reads, probability result, argmax.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bdbp_pkg::ST_IDLE: acc_q <= '0;
			bdbp_pkg::ST_SWEEP: acc_q <= sweep_sum;
			bdbp_pkg::ST_RD_MID: p_lo_q <= p_rd;
			bdbp_pkg::ST_RD_HI: p_mid_q <= p_rd;
			bdbp_pkg::ST_DIVIDE: begin
				if (div_done) prob_one <= quot;
			end
			bdbp_pkg::ST_ARGMAX: begin
				if (idx_q[SB-1:0] == lo_q) begin
					best_q <= lo_q;
					best_w_q <= w_rd;
				end else if (w_rd > best_w_q) begin
					best_q <= idx_q[SB-1:0];
					best_w_q <= w_rd;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign likely_symbol = best_q;
	assign range_low = lo_q;
	assign range_high = hi_q;
endmodule

// ===== design/bdbp_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the bit probability.
// Depends on bdbp_pkg for widths.
module bdbp_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [bdbp_pkg::SUM_BITS-1:0] upper,
	input logic [bdbp_pkg::SUM_BITS-1:0] total,
	output logic done,
	output logic [bdbp_pkg::PROB_BITS-1:0] quotient
);
	localparam int CNT_BITS = $clog2(bdbp_pkg::DIV_BITS + 1);

	logic [bdbp_pkg::DIV_BITS-1:0] num_q;
	logic [bdbp_pkg::SUM_BITS:0] rem_q;
	logic [bdbp_pkg::SUM_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [bdbp_pkg::SUM_BITS:0] trial;
	logic [bdbp_pkg::SUM_BITS:0] diff;

	assign trial = {rem_q[bdbp_pkg::SUM_BITS-1:0], num_q[bdbp_pkg::DIV_BITS-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(bdbp_pkg::DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {upper, {bdbp_pkg::PROB_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= total;
		end else if (busy_q) begin
			if (!diff[bdbp_pkg::SUM_BITS]) begin
				rem_q <= diff;
				num_q <= {num_q[bdbp_pkg::DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[bdbp_pkg::DIV_BITS-2:0], 1'b0};
			end
		end
	end

	// Quotient bits collect in the low end of num_q; clamp to 16 bits, and give one half (0x8000) when the total is zero.
	always_comb begin
		if (den_q == '0) begin
			quotient = bdbp_pkg::PROB_BITS'(1 << (bdbp_pkg::PROB_BITS - 1));
		end else if (|num_q[bdbp_pkg::DIV_BITS-1:bdbp_pkg::PROB_BITS]) begin
			quotient = '1;
		end else begin
			quotient = num_q[bdbp_pkg::PROB_BITS-1:0];
		end
	end
endmodule

// ===== tb/tb.sv =====
// Testbench for byte_distribution_bit_predictor_core.
// Drives load, observe, restart and unused requests and mask writes, predicts every result and checks it.
// Depends on bdbp_pkg and the core RTL.
module tb;
	typedef struct packed {
		bdbp_pkg::action_t act;
		logic [7:0] sym;
		logic [23:0] cnt;
		logic last;
		logic bv;
	} request_t;

	typedef struct packed {
		logic [15:0] prob;
		logic [7:0] likely;
		logic [7:0] lo;
		logic [7:0] hi;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] action = 0;
	logic [7:0] symbol_index = 0;
	logic [23:0] symbol_count = 0;
	logic last_entry = 0;
	logic bit_value = 0;
	logic done;
	logic [15:0] prob_one;
	logic [7:0] likely_symbol;
	logic [7:0] range_low;
	logic [7:0] range_high;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;

	byte_distribution_bit_predictor_core u_top (.*);

	always #6 clk = ~clk;

	logic [63:0] mask_regs [4];
	logic [23:0] weights [256];
	logic [63:0] prefix [257];
	int lower_bound_q, upper_bound_q;

	request_t pending_requests [$];
	answer_t expected_answers [$];
	int errors = 0;
	int answers_seen = 0;
	int loads_sent = 0, observes_sent = 0, restarts_sent = 0;
	bit gaps_on = 1;
	int gap_left = 0;

	function automatic bit is_allowed(int s);
		return mask_regs[s / 64][s % 64];
	endfunction

	function automatic void rebuild_prefix();
		prefix[0] = 0;
		for (int i = 0; i < 256; i++) prefix[i + 1] = prefix[i] + weights[i];
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		int mid, best;
		logic [63:0] lm, um, tot, p;
		case (r.act)
			bdbp_pkg::ACT_LOAD: begin
				if (is_allowed(r.sym)) weights[r.sym] = (r.cnt == 0) ? 24'd1 : r.cnt;
				else weights[r.sym] = 0;
				if (r.last) begin
					rebuild_prefix();
					lower_bound_q = 0;
					upper_bound_q = 255;
				end
			end
			bdbp_pkg::ACT_OBSERVE: begin
				if (lower_bound_q < upper_bound_q) begin
					mid = lower_bound_q + (upper_bound_q - lower_bound_q) / 2;
					if (r.bv) lower_bound_q = mid + 1;
					else upper_bound_q = mid;
				end
			end
			bdbp_pkg::ACT_RESTART: begin
				for (int i = 0; i < 256; i++) if (!is_allowed(i)) weights[i] = 0;
				rebuild_prefix();
				lower_bound_q = 0;
				upper_bound_q = 255;
			end
			default: ;
		endcase
		mid = lower_bound_q + (upper_bound_q - lower_bound_q) / 2;
		lm = prefix[mid + 1] - prefix[lower_bound_q];
		um = prefix[upper_bound_q + 1] - prefix[mid + 1];
		tot = lm + um;
		if (tot == 0) p = 32768;
		else begin
			p = (um << 16) / tot;
			if (p > 65535) p = 65535;
		end
		best = lower_bound_q;
		for (int i = lower_bound_q + 1; i <= upper_bound_q; i++)
			if (weights[i] > weights[best]) best = i;
		a.prob = p[15:0];
		a.likely = best[7:0];
		a.lo = lower_bound_q[7:0];
		a.hi = upper_bound_q[7:0];
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Driver: holds start until the block takes the request.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_answers.push_back(predict_answer({bdbp_pkg::action_t'(action),
				symbol_index, symbol_count, last_entry, bit_value}));
		end
		if (start && busy) begin
		end else if (gap_left > 0) begin
			start <= 0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			request_t r;
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				start <= 0;
				gap_left <= $urandom_range(0, 9);
			end else begin
				r = pending_requests.pop_front();
				start <= 1;
				action <= r.act;
				symbol_index <= r.sym;
				symbol_count <= r.cnt;
				last_entry <= r.last;
				bit_value <= r.bv;
			end
		end else begin
			start <= 0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			answer_t w;
			answers_seen++;
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = expected_answers.pop_front();
				if (prob_one !== w.prob) report_mismatch("prob_one", prob_one, w.prob);
				if (likely_symbol !== w.likely)
					report_mismatch("likely_symbol", likely_symbol, w.likely);
				if (range_low !== w.lo) report_mismatch("range_low", range_low, w.lo);
				if (range_high !== w.hi) report_mismatch("range_high", range_high, w.hi);
			end
		end
	end

	function automatic request_t make_request(bdbp_pkg::action_t a, int s, int c, bit l,
		bit b);
		request_t r;
		r.act = a;
		r.sym = s[7:0];
		r.cnt = c[23:0];
		r.last = l;
		r.bv = b;
		return r;
	endfunction

	task automatic queue_request(request_t r);
		pending_requests.push_back(r);
		case (r.act)
			bdbp_pkg::ACT_LOAD: loads_sent++;
			bdbp_pkg::ACT_OBSERVE: observes_sent++;
			bdbp_pkg::ACT_RESTART: restarts_sent++;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || start || busy || expected_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mask(int idx, logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= idx[1:0];
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mask_regs[idx] = val;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic int rand_count();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return $urandom_range(1, 15);
			default: return $urandom & 24'hFFFFFF;
		endcase
	endfunction

	task automatic queue_byte_walk();
		int n;
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++)
			queue_request(make_request(bdbp_pkg::ACT_OBSERVE, $urandom, $urandom,
				$urandom_range(0, 1), $urandom_range(0, 1)));
	endtask

	initial begin
		for (int i = 0; i < 4; i++) mask_regs[i] = '1;
		for (int i = 0; i < 256; i++) weights[i] = 1;
		for (int i = 0; i <= 256; i++) prefix[i] = i;
		lower_bound_q = 0;
		upper_bound_q = 255;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed: fresh state, extremes of the count, every action.
		queue_request(make_request(bdbp_pkg::ACT_NONE, 0, 0, 0, 0));
		for (int i = 0; i < 9; i++)
			queue_request(make_request(bdbp_pkg::ACT_OBSERVE, 0, 0, 0, 1));
		queue_request(make_request(bdbp_pkg::ACT_LOAD, 0, 0, 0, 0));
		queue_request(make_request(bdbp_pkg::ACT_LOAD, 255, 24'hFFFFFF, 0, 1));
		queue_request(make_request(bdbp_pkg::ACT_LOAD, 7, 500, 1, 0));
		for (int i = 0; i < 8; i++)
			queue_request(make_request(bdbp_pkg::ACT_OBSERVE, 0, 0, 0, i % 2));
		queue_request(make_request(bdbp_pkg::ACT_RESTART, 0, 0, 0, 0));
		drain();

		// Everything masked: no mass anywhere.
		for (int i = 0; i < 4; i++) write_mask(i, 64'd0);
		queue_request(make_request(bdbp_pkg::ACT_LOAD, 3, 99, 1, 0));
		queue_request(make_request(bdbp_pkg::ACT_RESTART, 0, 0, 0, 0));
		queue_request(make_request(bdbp_pkg::ACT_OBSERVE, 0, 0, 0, 1));
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			for (int i = 0; i < 4; i++) begin
				case ($urandom_range(0, 3))
					0: write_mask(i, '1);
					1: write_mask(i, '0);
					default: write_mask(i, {$urandom, $urandom});
				endcase
			end
			gaps_on = (phase < 5);
			for (int k = 0; k < 95; k++) begin
				int sel;
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					queue_request(make_request(bdbp_pkg::ACT_LOAD, $urandom, rand_count(),
						$urandom_range(0, 3) == 0, $urandom_range(0, 1)));
				end else if (sel < 8) begin
					queue_byte_walk();
				end else if (sel == 8) begin
					queue_request(make_request(bdbp_pkg::ACT_RESTART, $urandom, $urandom,
						$urandom_range(0, 1), $urandom_range(0, 1)));
				end else begin
					queue_request(make_request(bdbp_pkg::ACT_NONE, $urandom, $urandom,
						$urandom_range(0, 1), $urandom_range(0, 1)));
				end
			end
			drain();
		end

		$display("Sent %0d loads, %0d observes and %0d restarts; %0d results checked.",
			loads_sent, observes_sent, restarts_sent, answers_seen);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Timeout waiting for results");
		$display("Some tests failed");
		$finish;
	end
endmodule

// ===== sim.f =====
design/bdbp_pkg.sv
design/bdbp_divider.sv
design/byte_distribution_bit_predictor_core.sv
tb/tb.sv
